// ===== hdl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes and inter-stage types of the ray/sphere
// intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CRD_W     = 32;
  localparam int RSQ_W     = 31;
  localparam int T_W       = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SQ = 2'd3;

  localparam logic [RSQ_W-1:0] RSQ_RESET = RSQ_W'(1) << FRAC_BITS;
  localparam logic signed [CRD_W-1:0] NORM_ONE = CRD_W'(1) << FRAC_BITS;

  localparam int L_W   = CRD_W + 1;
  localparam int A_W   = 2 * CRD_W - FRAC_BITS;
  localparam int H_W   = 2 * CRD_W + 2 - FRAC_BITS;
  localparam int C_W   = 2 * CRD_W + 3 - FRAC_BITS;
  localparam int DSC_W = 2 * H_W;
  localparam int S_W   = DSC_W / 2;
  localparam int N_W   = S_W + 1;
  localparam int DV_W  = A_W + T_W;
  localparam int VS_W  = 2 * L_W;
  localparam int LEN_W = L_W;
  localparam int NQ_W  = FRAC_BITS + 1;
  localparam int NR_W  = L_W + FRAC_BITS;

  typedef logic [2:0][CRD_W-1:0] vec3_t;
  typedef logic [2:0][L_W-1:0]   lvec3_t;

  typedef struct packed {
    logic                    valid;
    logic                    miss;
    vec3_t                   o;
    vec3_t                   d;
    logic signed [H_W-1:0]   h;
    logic [A_W-1:0]          a;
    logic [DSC_W-1:0]        disc;
  } quad_t;

  typedef struct packed {
    logic           valid;
    logic           miss;
    vec3_t          o;
    vec3_t          d;
    logic [T_W-1:0] t;
  } root_t;

  typedef struct packed {
    logic            valid;
    logic            miss;
    logic [T_W-1:0]  t;
    vec3_t           p;
    logic [2:0]      vneg;
    lvec3_t          vmag;
    logic [VS_W-1:0] vs;
  } pnt_t;

  typedef struct packed {
    logic           valid;
    logic           hit;
    logic [T_W-1:0] distance;
    vec3_t          p;
    vec3_t          n;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/rsi_if.sv =====
// ----------------------------------------------------------------------------
// rsi_if
// Valid/ready channels for rays in and intersection results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rsi_ray_if;
  import rsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] origin_x;
  logic signed [CRD_W-1:0] origin_y;
  logic signed [CRD_W-1:0] origin_z;
  logic signed [CRD_W-1:0] dir_x;
  logic signed [CRD_W-1:0] dir_y;
  logic signed [CRD_W-1:0] dir_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

interface rsi_hit_if;
  import rsi_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [T_W-1:0]          distance;
  logic signed [CRD_W-1:0] point_x;
  logic signed [CRD_W-1:0] point_y;
  logic signed [CRD_W-1:0] point_z;
  logic signed [CRD_W-1:0] normal_x;
  logic signed [CRD_W-1:0] normal_y;
  logic signed [CRD_W-1:0] normal_z;
  modport source (output valid, hit, distance, point_x, point_y, point_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, hit, distance, point_x, point_y, point_z,
                normal_x, normal_y, normal_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/rsi_quad.sv =====
// ----------------------------------------------------------------------------
// rsi_quad
// Six stages: offset, products, quadratic terms a/h/c, partial products of
// h^2 and a*|c|, their sums, and the discriminant with early miss.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_quad (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  rsi_pkg::vec3_t        o,
  input  rsi_pkg::vec3_t        d,
  input  rsi_pkg::vec3_t        center,
  input  logic [rsi_pkg::RSQ_W-1:0] rsq,
  output rsi_pkg::quad_t        q_o
);
  import rsi_pkg::*;

  localparam int HM_W = H_W - 1;
  localparam int HL_W = HM_W / 2;
  localparam int HH_W = HM_W - HL_W;
  localparam int CM_W = C_W - 1;
  localparam int CL_W = CM_W / 2;
  localparam int CH_W = CM_W - CL_W;
  localparam int AL_W = A_W / 2;
  localparam int AH_W = A_W - AL_W;

  logic [5:0] v_r;

  vec3_t o1_r, d1_r, o2_r, d2_r, o3_r, d3_r, o4_r, d4_r, o5_r, d5_r, o6_r, d6_r;
  lvec3_t l1_r, l_nxt;
  logic [2:0][2*CRD_W-1:0]     dd2_r, dd_nxt;
  logic [2:0][CRD_W+L_W-1:0]   dl2_r, dl_nxt;
  logic [2:0][2*L_W-1:0]       ll2_r, ll_nxt;

  logic [A_W-1:0]          a3_r, a4_r, a5_r, a6_r, a_nxt;
  logic signed [H_W-1:0]   h3_r, h4_r, h5_r, h6_r, h_nxt;
  logic signed [C_W-1:0]   c3_r, c_nxt;

  logic [HM_W-1:0] hm;
  logic [CM_W-1:0] cm;
  logic            azero4_r, cneg4_r, azero5_r, cneg5_r, miss6_r;
  logic [2*HL_W-1:0]       ph_ll_r;
  logic [HL_W+HH_W-1:0]    ph_lh_r;
  logic [2*HH_W-1:0]       ph_hh_r;
  logic [AL_W+CL_W-1:0]    pa_ll_r;
  logic [AL_W+CH_W-1:0]    pa_lh_r;
  logic [AH_W+CL_W-1:0]    pa_hl_r;
  logic [AH_W+CH_W-1:0]    pa_hh_r;
  logic [DSC_W-1:0]        hh_nxt, ac_nxt, hh5_r, ac5_r, disc6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_nxt[i]  = L_W'($signed(o[i])) - L_W'($signed(center[i]));
      dd_nxt[i] = $signed(d1_r[i]) * $signed(d1_r[i]);
      dl_nxt[i] = $signed(d1_r[i]) * $signed(l1_r[i]);
      ll_nxt[i] = $signed(l1_r[i]) * $signed(l1_r[i]);
    end
    a_nxt = A_W'(dd2_r[0] >> FRAC_BITS) + A_W'(dd2_r[1] >> FRAC_BITS)
          + A_W'(dd2_r[2] >> FRAC_BITS);
    h_nxt = H_W'($signed(dl2_r[0]) >>> FRAC_BITS) + H_W'($signed(dl2_r[1]) >>> FRAC_BITS)
          + H_W'($signed(dl2_r[2]) >>> FRAC_BITS);
    c_nxt = C_W'(ll2_r[0] >> FRAC_BITS) + C_W'(ll2_r[1] >> FRAC_BITS)
          + C_W'(ll2_r[2] >> FRAC_BITS) - C_W'(rsq);
    hm = h3_r[H_W-1] ? HM_W'(-h3_r) : h3_r[HM_W-1:0];
    cm = c3_r[C_W-1] ? CM_W'(-c3_r) : c3_r[CM_W-1:0];
    hh_nxt = (DSC_W'(ph_hh_r) << (2 * HL_W)) + (DSC_W'(ph_lh_r) << (HL_W + 1))
           + DSC_W'(ph_ll_r);
    ac_nxt = (DSC_W'(pa_hh_r) << (AL_W + CL_W)) + (DSC_W'(pa_lh_r) << CL_W)
           + (DSC_W'(pa_hl_r) << AL_W) + DSC_W'(pa_ll_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o1_r <= o;    d1_r <= d;    l1_r <= l_nxt;
      o2_r <= o1_r; d2_r <= d1_r;
      dd2_r <= dd_nxt; dl2_r <= dl_nxt; ll2_r <= ll_nxt;
      o3_r <= o2_r; d3_r <= d2_r;
      a3_r <= a_nxt; h3_r <= h_nxt; c3_r <= c_nxt;
      o4_r <= o3_r; d4_r <= d3_r; a4_r <= a3_r; h4_r <= h3_r;
      azero4_r <= (a3_r == '0);
      cneg4_r  <= c3_r[C_W-1];
      ph_ll_r  <= hm[HL_W-1:0] * hm[HL_W-1:0];
      ph_lh_r  <= hm[HL_W-1:0] * hm[HM_W-1:HL_W];
      ph_hh_r  <= hm[HM_W-1:HL_W] * hm[HM_W-1:HL_W];
      pa_ll_r  <= a3_r[AL_W-1:0] * cm[CL_W-1:0];
      pa_lh_r  <= a3_r[AL_W-1:0] * cm[CM_W-1:CL_W];
      pa_hl_r  <= a3_r[A_W-1:AL_W] * cm[CL_W-1:0];
      pa_hh_r  <= a3_r[A_W-1:AL_W] * cm[CM_W-1:CL_W];
      o5_r <= o4_r; d5_r <= d4_r; a5_r <= a4_r; h5_r <= h4_r;
      azero5_r <= azero4_r; cneg5_r <= cneg4_r;
      hh5_r <= hh_nxt; ac5_r <= ac_nxt;
      o6_r <= o5_r; d6_r <= d5_r; a6_r <= a5_r; h6_r <= h5_r;
      disc6_r <= cneg5_r ? hh5_r + ac5_r : hh5_r - ac5_r;
      miss6_r <= azero5_r | (!cneg5_r && (hh5_r < ac5_r));
    end
  end

  assign q_o = '{valid: v_r[5], miss: miss6_r, o: o6_r, d: d6_r, h: h6_r, a: a6_r,
                 disc: disc6_r};

endmodule

`default_nettype wire

// ===== hdl/rsi_root.sv =====
// ----------------------------------------------------------------------------
// rsi_root
// Bit-per-stage square root of the discriminant, root selection, and a
// bit-per-stage restoring divide giving the saturated distance t.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_root (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rsi_pkg::quad_t q_i,
  output rsi_pkg::root_t r_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic                  miss;
    vec3_t                 o;
    vec3_t                 d;
    logic signed [H_W-1:0] h;
    logic [A_W-1:0]        a;
  } sq_side_t;

  typedef struct packed {
    logic           miss;
    vec3_t          o;
    vec3_t          d;
    logic [A_W-1:0] a;
    logic           ovf;
  } dv_side_t;

  logic [S_W-1:0]              sv_r;
  sq_side_t [S_W-1:0]          sside_r;
  sq_side_t                    sside_in;
  logic [S_W-1:0][DSC_W-1:0]   srem_r;
  logic [S_W-1:0][S_W-1:0]     sroot_r;

  logic                        sel_v_r, ov_v_r;
  logic [N_W-1:0]              sel_n_r;
  dv_side_t                    sel_side_r, ov_side_r, sel_side_nxt;
  logic [N_W:0]                hx, sx, n0, n1;
  logic [DV_W-1:0]             num, ov_rem_r;

  logic [T_W-1:0]              dv_r;
  dv_side_t [T_W-1:0]          dside_r;
  logic [T_W-1:0][DV_W-1:0]    drem_r;
  logic [T_W-1:0][T_W-1:0]     dq_r;

  assign sside_in = '{miss: q_i.miss, o: q_i.o, d: q_i.d, h: q_i.h, a: q_i.a};

  for (genvar k = 0; k < S_W; k++) begin : g_sqrt
    localparam int B = S_W - 1 - k;
    logic [DSC_W-1:0] rem_in, trial;
    logic [S_W-1:0]   root_in;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in  = q_i.disc;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
    end
    assign trial = (DSC_W'(root_in) << (B + 1)) | (DSC_W'(1) << (2 * B));
    assign ge    = rem_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k]  <= ge ? rem_in - trial : rem_in;
        sroot_r[k] <= ge ? (root_in | (S_W'(1) << B)) : root_in;
      end
    end
  end

  always_comb begin
    hx = (N_W+1)'($signed(sside_r[S_W-1].h));
    sx = (N_W+1)'(sroot_r[S_W-1]);
    n0 = -hx - sx;
    n1 = -hx + sx;
    num = DV_W'({sel_n_r, {FRAC_BITS{1'b0}}});
    sel_side_nxt = '{miss: sside_r[S_W-1].miss | (n0[N_W] & n1[N_W]),
                     o: sside_r[S_W-1].o, d: sside_r[S_W-1].d,
                     a: sside_r[S_W-1].a, ovf: 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r    <= '0;
      sel_v_r <= 1'b0;
      ov_v_r  <= 1'b0;
      dv_r    <= '0;
    end else if (en) begin
      sv_r    <= {sv_r[S_W-2:0], q_i.valid};
      sel_v_r <= sv_r[S_W-1];
      ov_v_r  <= sel_v_r;
      dv_r    <= {dv_r[T_W-2:0], ov_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sside_r    <= {sside_r[S_W-2:0], sside_in};
      sel_n_r    <= n0[N_W] ? n1[N_W-1:0] : n0[N_W-1:0];
      sel_side_r <= sel_side_nxt;
      ov_rem_r   <= num;
      ov_side_r  <= '{miss: sel_side_r.miss, o: sel_side_r.o, d: sel_side_r.d,
                      a: sel_side_r.a,
                      ovf: num >= (DV_W'(sel_side_r.a) << T_W)};
    end
  end

  for (genvar k = 0; k < T_W; k++) begin : g_div
    localparam int B = T_W - 1 - k;
    logic [DV_W-1:0] rem_in, dvs;
    logic [T_W-1:0]  q_in;
    dv_side_t        side_in;
    logic            ge;
    if (k == 0) begin : g_first
      assign rem_in  = ov_rem_r;
      assign q_in    = '0;
      assign side_in = ov_side_r;
    end else begin : g_next
      assign rem_in  = drem_r[k-1];
      assign q_in    = dq_r[k-1];
      assign side_in = dside_r[k-1];
    end
    assign dvs = DV_W'(side_in.a) << B;
    assign ge  = rem_in >= dvs;
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k]  <= ge ? rem_in - dvs : rem_in;
        dq_r[k]    <= ge ? (q_in | (T_W'(1) << B)) : q_in;
        dside_r[k] <= side_in;
      end
    end
  end

  assign r_o = '{valid: dv_r[T_W-1], miss: dside_r[T_W-1].miss,
                 o: dside_r[T_W-1].o, d: dside_r[T_W-1].d,
                 t: dside_r[T_W-1].ovf ? {T_W{1'b1}} : dq_r[T_W-1]};

endmodule

`default_nettype wire

// ===== hdl/rsi_point.sv =====
// ----------------------------------------------------------------------------
// rsi_point
// Hit point o + d*t with saturation, offset from centre, its magnitude per
// axis and the squared length.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_point (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  rsi_pkg::root_t r_i,
  input  rsi_pkg::vec3_t center,
  output rsi_pkg::pnt_t  p_o
);
  import rsi_pkg::*;

  localparam int PR_W = CRD_W + T_W + 1;
  localparam int SM_W = PR_W - FRAC_BITS + 1;

  logic [4:0] v_r;
  logic       miss1_r, miss2_r, miss3_r, miss4_r, miss5_r;
  logic [T_W-1:0] t1_r, t2_r, t3_r, t4_r, t5_r;
  vec3_t      o1_r, p2_r, p3_r, p4_r, p5_r, p_nxt;
  logic [2:0][PR_W-1:0]  prod1_r, prod_nxt;
  logic [2:0][SM_W-1:0]  sm;
  lvec3_t     v3_r, v_nxt, vmag4_r, vmag5_r, vmag_nxt;
  logic [2:0] vneg4_r, vneg5_r;
  logic [2:0][2*L_W-1:0] sq4_r, sq_nxt;
  logic [VS_W-1:0] vs5_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = $signed(r_i.d[i]) * $signed({1'b0, r_i.t});
      sm[i] = SM_W'($signed(o1_r[i])) + SM_W'($signed(prod1_r[i]) >>> FRAC_BITS);
      if ((&sm[i][SM_W-1:CRD_W-1]) || !(|sm[i][SM_W-1:CRD_W-1])) begin
        p_nxt[i] = sm[i][CRD_W-1:0];
      end else if (sm[i][SM_W-1]) begin
        p_nxt[i] = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        p_nxt[i] = {1'b0, {(CRD_W-1){1'b1}}};
      end
      v_nxt[i]    = L_W'($signed(p2_r[i])) - L_W'($signed(center[i]));
      vmag_nxt[i] = v3_r[i][L_W-1] ? -v3_r[i] : v3_r[i];
      sq_nxt[i]   = $signed(v3_r[i]) * $signed(v3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], r_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      miss1_r <= r_i.miss; t1_r <= r_i.t; o1_r <= r_i.o; prod1_r <= prod_nxt;
      miss2_r <= miss1_r;  t2_r <= t1_r;  p2_r <= p_nxt;
      miss3_r <= miss2_r;  t3_r <= t2_r;  p3_r <= p2_r; v3_r <= v_nxt;
      miss4_r <= miss3_r;  t4_r <= t3_r;  p4_r <= p3_r;
      vmag4_r <= vmag_nxt;
      for (int i = 0; i < 3; i++) begin
        vneg4_r[i] <= v3_r[i][L_W-1];
      end
      sq4_r   <= sq_nxt;
      miss5_r <= miss4_r;  t5_r <= t4_r;  p5_r <= p4_r;
      vmag5_r <= vmag4_r;  vneg5_r <= vneg4_r;
      vs5_r   <= VS_W'(sq4_r[0]) + VS_W'(sq4_r[1]) + VS_W'(sq4_r[2]);
    end
  end

  assign p_o = '{valid: v_r[4], miss: miss5_r, t: t5_r, p: p5_r, vneg: vneg5_r,
                 vmag: vmag5_r, vs: vs5_r};

endmodule

`default_nettype wire

// ===== hdl/rsi_norm.sv =====
// ----------------------------------------------------------------------------
// rsi_norm
// Bit-per-stage square root of the squared length, three-lane bit-per-stage
// divide for the unit normal, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  rsi_pkg::pnt_t p_i,
  output rsi_pkg::res_t r_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic           miss;
    logic [T_W-1:0] t;
    vec3_t          p;
    logic [2:0]     vneg;
    lvec3_t         vmag;
  } sq_side_t;

  typedef struct packed {
    logic             miss;
    logic [T_W-1:0]   t;
    vec3_t            p;
    logic [2:0]       vneg;
    logic [LEN_W-1:0] len;
  } dv_side_t;

  logic [LEN_W-1:0]              sv_r;
  sq_side_t [LEN_W-1:0]          sside_r;
  sq_side_t                      sside_in;
  logic [LEN_W-1:0][VS_W-1:0]    srem_r;
  logic [LEN_W-1:0][LEN_W-1:0]   sroot_r;

  logic [NQ_W-1:0]               dv_r;
  dv_side_t [NQ_W-1:0]           dside_r;
  logic [NQ_W-1:0][2:0][NR_W-1:0] drem_r;
  logic [NQ_W-1:0][2:0][NQ_W-1:0] dq_r;

  dv_side_t fin;
  vec3_t    n_nxt;
  res_t     res_r;
  logic     res_v_r;

  assign sside_in = '{miss: p_i.miss, t: p_i.t, p: p_i.p, vneg: p_i.vneg,
                      vmag: p_i.vmag};

  for (genvar k = 0; k < LEN_W; k++) begin : g_sqrt
    localparam int B = LEN_W - 1 - k;
    logic [VS_W-1:0]  rem_in, trial;
    logic [LEN_W-1:0] root_in;
    logic             ge;
    if (k == 0) begin : g_first
      assign rem_in  = p_i.vs;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = srem_r[k-1];
      assign root_in = sroot_r[k-1];
    end
    assign trial = (VS_W'(root_in) << (B + 1)) | (VS_W'(1) << (2 * B));
    assign ge    = rem_in >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        srem_r[k]  <= ge ? rem_in - trial : rem_in;
        sroot_r[k] <= ge ? (root_in | (LEN_W'(1) << B)) : root_in;
      end
    end
  end

  for (genvar k = 0; k < NQ_W; k++) begin : g_div
    localparam int B = NQ_W - 1 - k;
    dv_side_t side_in;
    logic [2:0][NR_W-1:0] rem_in;
    logic [2:0][NQ_W-1:0] q_in;
    logic [NR_W-1:0]      dvs;
    if (k == 0) begin : g_first
      assign side_in = '{miss: sside_r[LEN_W-1].miss, t: sside_r[LEN_W-1].t,
                         p: sside_r[LEN_W-1].p, vneg: sside_r[LEN_W-1].vneg,
                         len: sroot_r[LEN_W-1]};
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_in[i] = {sside_r[LEN_W-1].vmag[i], {FRAC_BITS{1'b0}}};
      end
      assign q_in = '0;
    end else begin : g_next
      assign side_in = dside_r[k-1];
      assign rem_in  = drem_r[k-1];
      assign q_in    = dq_r[k-1];
    end
    assign dvs = NR_W'(side_in.len) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dside_r[k] <= side_in;
        for (int i = 0; i < 3; i++) begin
          if (rem_in[i] >= dvs) begin
            drem_r[k][i] <= rem_in[i] - dvs;
            dq_r[k][i]   <= q_in[i] | (NQ_W'(1) << B);
          end else begin
            drem_r[k][i] <= rem_in[i];
            dq_r[k][i]   <= q_in[i];
          end
        end
      end
    end
  end

  always_comb begin
    fin = dside_r[NQ_W-1];
    for (int i = 0; i < 3; i++) begin
      if (fin.len == '0 || fin.miss) begin
        n_nxt[i] = '0;
      end else if (fin.vneg[i]) begin
        n_nxt[i] = -CRD_W'(dq_r[NQ_W-1][i]);
      end else begin
        n_nxt[i] = CRD_W'(dq_r[NQ_W-1][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r    <= '0;
      dv_r    <= '0;
      res_v_r <= 1'b0;
    end else if (en) begin
      sv_r    <= {sv_r[LEN_W-2:0], p_i.valid};
      dv_r    <= {dv_r[NQ_W-2:0], sv_r[LEN_W-1]};
      res_v_r <= dv_r[NQ_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sside_r        <= {sside_r[LEN_W-2:0], sside_in};
      res_r.valid    <= 1'b0;
      res_r.hit      <= !fin.miss;
      res_r.distance <= fin.miss ? '0 : fin.t;
      res_r.p        <= fin.miss ? '0 : fin.p;
      res_r.n        <= n_nxt;
    end
  end

  assign r_o = '{valid: res_v_r, hit: res_r.hit, distance: res_r.distance,
                 p: res_r.p, n: res_r.n};

endmodule

`default_nettype wire

// ===== hdl/ray_sphere_intersect_core.sv =====
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray/sphere intersector: quadratic terms, discriminant root, distance,
// hit point and unit normal in one fully pipelined datapath.
// ----------------------------------------------------------------------------
// Throughput: one ray per cycle while the output is not stalled; set by the pipeline, every stage registered.
// The square roots and divides resolve one result bit per stage.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset (synchronous): pipeline emptied, centre 0, squared radius 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsi_pkg::CRD_W-1:0]     cfg_data,
  rsi_ray_if.sink                       in_ray,
  rsi_hit_if.source                     out_hit
);
  import rsi_pkg::*;

  vec3_t            center_r;
  logic [RSQ_W-1:0] rsq_r;
  vec3_t            o_in, d_in;
  logic             en;
  quad_t            quad;
  root_t            root;
  pnt_t             pnt;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      rsq_r    <= RSQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_r[0] <= cfg_data;
        REG_CENTER_Y:  center_r[1] <= cfg_data;
        REG_CENTER_Z:  center_r[2] <= cfg_data;
        REG_RADIUS_SQ: rsq_r       <= cfg_data[RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  assign en   = !res.valid || out_hit.ready;
  assign o_in = {in_ray.origin_z, in_ray.origin_y, in_ray.origin_x};
  assign d_in = {in_ray.dir_z, in_ray.dir_y, in_ray.dir_x};
  assign in_ray.ready = en;

  rsi_quad u_quad (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_ray.valid),
    .o(o_in), .d(d_in), .center(center_r), .rsq(rsq_r), .q_o(quad)
  );

  rsi_root u_root (
    .clk(clk), .rst_n(rst_n), .en(en), .q_i(quad), .r_o(root)
  );

  rsi_point u_point (
    .clk(clk), .rst_n(rst_n), .en(en), .r_i(root), .center(center_r), .p_o(pnt)
  );

  rsi_norm u_norm (
    .clk(clk), .rst_n(rst_n), .en(en), .p_i(pnt), .r_o(res)
  );

  assign out_hit.valid    = res.valid;
  assign out_hit.hit      = res.hit;
  assign out_hit.distance = res.distance;
  assign out_hit.point_x  = res.p[0];
  assign out_hit.point_y  = res.p[1];
  assign out_hit.point_z  = res.p[2];
  assign out_hit.normal_x = res.n[0];
  assign out_hit.normal_y = res.n[1];
  assign out_hit.normal_z = res.n[2];

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit.valid && !out_hit.hit |-> out_hit.distance == '0 &&
      out_hit.point_x == '0 && out_hit.point_y == '0 && out_hit.point_z == '0 &&
      out_hit.normal_x == '0 && out_hit.normal_y == '0 && out_hit.normal_z == '0)
    else $error("miss result carries non-zero fields");

  a_normal_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit.valid |-> out_hit.normal_x <= NORM_ONE && out_hit.normal_x >= -NORM_ONE &&
      out_hit.normal_y <= NORM_ONE && out_hit.normal_y >= -NORM_ONE &&
      out_hit.normal_z <= NORM_ONE && out_hit.normal_z >= -NORM_ONE)
    else $error("normal component exceeds one");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_hit.valid)
    else $error("result valid straight after reset");

endmodule

`default_nettype wire

// ===== verif/tb_ray_sphere_intersect_core.sv =====
// ----------------------------------------------------------------------------
// tb_ray_sphere_intersect_core
// Self-checking bench for the ray/sphere intersector. Rays are sent through
// the valid/ready channel and each result is compared with a bit-exact
// fixed-point prediction of the root choice, hit point and unit normal.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ray_sphere_intersect_core;
  import rsi_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic [T_W-1:0]          distance;
    logic signed [CRD_W-1:0] px, py, pz, nx, ny, nz;
  } hit_rec_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRD_W-1:0] cfg_data;

  rsi_ray_if ray_ch ();
  rsi_hit_if hit_ch ();

  ray_sphere_intersect_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ray    (ray_ch.sink),
    .out_hit   (hit_ch.source)
  );

  logic signed [CRD_W-1:0] ctr [3];
  logic [RSQ_W-1:0] rsq;

  hit_rec_t hits_due [$];
  int errors;
  int n_rays;
  int n_hits;
  int n_checked;
  bit sink_calm;
  bit src_calm;
  int hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [127:0] fshr(input logic signed [127:0] x);
    return x >>> FRAC_BITS;
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] x);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] clamp32(input logic signed [127:0] x);
    if (x > 128'sd2147483647) return 128'sd2147483647;
    if (x < -128'sd2147483648) return -128'sd2147483648;
    return x;
  endfunction

  function automatic hit_rec_t trace_ray(input logic signed [CRD_W-1:0] o [3],
                                         input logic signed [CRD_W-1:0] d [3]);
    hit_rec_t r;
    logic signed [127:0] lv [3];
    logic signed [127:0] pt [3];
    logic signed [127:0] a, h, c, disc, s, nm, t, vs, len, m;
    r = '0;
    a = 0; h = 0; c = 0; vs = 0;
    for (int i = 0; i < 3; i++) begin
      lv[i] = 128'(o[i]) - 128'(ctr[i]);
      a += fshr(128'(d[i]) * 128'(d[i]));
      h += fshr(128'(d[i]) * lv[i]);
      c += fshr(lv[i] * lv[i]);
    end
    c -= 128'(rsq);
    if (a == 0) return r;
    disc = h * h - a * c;
    if (disc < 0) return r;
    s = isqrt(disc);
    if (-h - s >= 0) nm = -h - s;
    else if (-h + s >= 0) nm = -h + s;
    else return r;
    t = (nm <<< FRAC_BITS) / a;
    if (t > 128'sd2147483647) t = 128'sd2147483647;
    for (int i = 0; i < 3; i++) begin
      pt[i] = clamp32(128'(o[i]) + fshr(128'(d[i]) * t));
      lv[i] = pt[i] - 128'(ctr[i]);
      vs += lv[i] * lv[i];
    end
    len = isqrt(vs);
    r.hit = 1'b1;
    r.distance = t[T_W-1:0];
    r.px = pt[0][31:0];
    r.py = pt[1][31:0];
    r.pz = pt[2][31:0];
    for (int i = 0; i < 3; i++) begin
      m = 0;
      if (len != 0) begin
        m = ((lv[i] < 0 ? -lv[i] : lv[i]) <<< FRAC_BITS) / len;
        if (lv[i] < 0) m = -m;
      end
      case (i)
        0: r.nx = m[31:0];
        1: r.ny = m[31:0];
        default: r.nz = m[31:0];
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRD_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_X: ctr[0] = val;
      REG_CENTER_Y: ctr[1] = val;
      REG_CENTER_Z: ctr[2] = val;
      REG_RADIUS_SQ: rsq = val[RSQ_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_sphere(input logic [31:0] cx, cy, cz, input logic [31:0] r2);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS_SQ, r2);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    ray_ch.valid <= 1'b0;
    while (hits_due.size() != 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    if (hits_due.size() != 0) begin
      $display("Mismatches found");
      $finish;
    end
    repeat (160) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
    logic signed [CRD_W-1:0] o [3];
    logic signed [CRD_W-1:0] d [3];
    if (!src_calm && $urandom_range(0, 5) == 0) begin
      ray_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    o[0] = ox; o[1] = oy; o[2] = oz;
    d[0] = dx; d[1] = dy; d[2] = dz;
    ray_ch.valid <= 1'b1;
    ray_ch.origin_x <= ox;
    ray_ch.origin_y <= oy;
    ray_ch.origin_z <= oz;
    ray_ch.dir_x <= dx;
    ray_ch.dir_y <= dy;
    ray_ch.dir_z <= dz;
    do @(posedge clk); while (!ray_ch.ready);
    hits_due.push_back(trace_ray(o, d));
    n_rays++;
    @(negedge clk);
  endtask

  // small-magnitude Q16.16 value, uniform within +/- span
  function automatic logic [31:0] near_val(input int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] any_val();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h7fff_ffff};
      default: return near_val(1 << 20);
    endcase
  endfunction

  task automatic test_directed();
    set_sphere(32'h0, 32'h0, 32'h0, 32'h0001_0000);
    send_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(0, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(32'hfffb_0000, 32'h0005_0000, 0, 32'h0001_0000, 0, 0);
    send_ray(32'hfffb_0000, 0, 0, 0, 0, 0);
    send_ray(32'hfffb_0000, 0, 0, 32'h0000_00ff, 0, 0);
    send_ray(0, 32'hfffb_0000, 0, 0, 32'h0001_0000, 0);
    send_ray(0, 0, 32'h0005_0000, 0, 0, 32'hffff_0000);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'hffff_fff0, 0, 0, 32'h0000_0100, 0, 0);
    send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 1, 1);
    drain();
    set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h7fff_0000, 32'h8001_0000, 32'h7fff_0000, 32'h0001_0000, 0, 0);
    send_ray(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0000_0100, 32'h0001_0000, 0);
    drain();
    set_sphere(32'h0, 32'h0, 32'h0, 32'h0);
    send_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    send_ray(32'h0000_8000, 0, 0, 32'h0001_0000, 0, 0);
    drain();
  endtask

  task automatic test_random(input int rays);
    int span;
    for (int k = 0; k < rays; k++) begin
      if (k % 120 == 0) begin
        drain();
        if ($urandom_range(0, 2) == 0)
          set_sphere(any_val(), any_val(), any_val(), $urandom);
        else
          set_sphere(near_val(1 << 20), near_val(1 << 20), near_val(1 << 20),
                     $urandom_range(0, 1 << 22));
      end
      span = 1 << $urandom_range(16, 22);
      if ($urandom_range(0, 4) != 0)
        // mostly rays starting near the sphere centre, random direction
        send_ray(ctr[0] + near_val(span), ctr[1] + near_val(span), ctr[2] + near_val(span),
                 near_val(span), near_val(span), near_val(span));
      else
        send_ray(any_val(), any_val(), any_val(), any_val(), any_val(), any_val());
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int k = 0; k < 200; k++)
      send_ray(near_val(1 << 19), near_val(1 << 19), near_val(1 << 19),
               near_val(1 << 17), near_val(1 << 17), near_val(1 << 17));
    drain();
  endtask

  task automatic test_streaming();
    sink_calm = 1'b1;
    src_calm = 1'b1;
    for (int k = 0; k < 100; k++)
      send_ray(near_val(1 << 19), near_val(1 << 19), near_val(1 << 19),
               near_val(1 << 17), near_val(1 << 17), near_val(1 << 17));
    drain();
  endtask

  initial begin
    hit_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hit_ch.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      if (!sink_calm && $urandom_range(0, 6) == 0) begin
        hit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      hit_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    hit_rec_t want;
    hit_rec_t got;
    if (rst_n && hit_ch.valid && hit_ch.ready) begin
      got = {hit_ch.hit, hit_ch.distance, hit_ch.point_x, hit_ch.point_y, hit_ch.point_z,
             hit_ch.normal_x, hit_ch.normal_y, hit_ch.normal_z};
      if (hits_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer %p", $realtime, got);
      end else begin
        want = hits_due.pop_front();
        n_checked++;
        if (got.hit) n_hits++;
        if (got.hit !== want.hit)
          $display("%0t: hit exp %0d got %0d", $realtime, want.hit, got.hit);
        if (got.distance !== want.distance)
          $display("%0t: distance exp %0d got %0d", $realtime, want.distance, got.distance);
        if (got.px !== want.px || got.py !== want.py || got.pz !== want.pz)
          $display("%0t: point exp %0d %0d %0d got %0d %0d %0d", $realtime,
                   want.px, want.py, want.pz, got.px, got.py, got.pz);
        if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz)
          $display("%0t: normal exp %0d %0d %0d got %0d %0d %0d", $realtime,
                   want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    errors = 0; n_rays = 0; n_hits = 0; n_checked = 0;
    sink_calm = 1'b0; src_calm = 1'b0; hold_off = 0;
    ctr[0] = '0; ctr[1] = '0; ctr[2] = '0;
    rsq = RSQ_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CENTER_X;
    cfg_data = '0;
    ray_ch.valid = 1'b0;
    ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
    ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // reset sphere first: unit sphere at the origin
    send_ray(32'hfffd_0000, 0, 0, 32'h0001_0000, 0, 0);
    drain();
    test_directed();
    test_random(530);
    test_backpressure();
    test_streaming();
    $display("Sent %0d rays, checked %0d results, %0d hits.", n_rays, n_checked, n_hits);
    $display("Covered extremes, zero direction, misses, overflow, full-pipeline stall.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
